[design/tnl_pkg.sv]
// Shared types, constants and helpers for the 3D torus neighbour lister.
// No dependencies.
package tnl_pkg;

  localparam int CW         = 11;  // wrapped coordinate width
  localparam int SW         = 11;  // side length register width
  localparam int IW         = 30;  // row-major id width
  localparam int SLW        = 5;   // slot width
  localparam int FACE_COUNT = 6;
  localparam int BOX_COUNT  = 26;
  localparam int QDEPTH     = 4;
  localparam int ODEPTH     = 8;
  localparam int DEF_MAX_SIDE = 1024;
  localparam logic [SW-1:0] SIDE_RESET = 11'd8;

  localparam logic REG_SIDE = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic MODE_FACE = 1'b0;
  localparam logic MODE_BOX  = 1'b1;

  typedef struct packed {
    logic [CW-1:0] val;
    logic          ctr;
  } slot_t;

  typedef slot_t [2:0] axis_t;

  typedef struct packed {
    logic          err;
    logic          mode;
    logic [IW-1:0] vid;
    axis_t [2:0]   ax;
  } qent_t;

  typedef struct packed {
    logic [IW-1:0]  vid;
    logic [SLW-1:0] slot;
    logic [IW-1:0]  nid;
    logic           last;
    logic           err;
  } oent_t;

  function automatic axis_t sort3(slot_t a, slot_t b, slot_t c);
    slot_t p;
    slot_t q;
    slot_t r;
    slot_t t;
    axis_t res;
    p = a;
    q = b;
    r = c;
    if (p.val > q.val) begin
      t = p; p = q; q = t;
    end
    if (q.val > r.val) begin
      t = q; q = r; r = t;
    end
    if (p.val > q.val) begin
      t = p; p = q; q = t;
    end
    res[0] = p;
    res[1] = q;
    res[2] = r;
    return res;
  endfunction

endpackage

[design/tnl_fifo.sv]
// Small flop-based queue, first word fall-through.
// No dependencies.
module tnl_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNW'(DEPTH));
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

[design/tnl_front.sv]
// Front end: checks a vertex, builds the sorted per-axis neighbour values
// and the vertex id. Depends on tnl_pkg.
module tnl_front #(
  parameter int MAX_SIDE = tnl_pkg::DEF_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [9:0]            in_coord_x,
  input  logic [9:0]            in_coord_y,
  input  logic [9:0]            in_coord_z,
  input  logic [tnl_pkg::SW-1:0] side,
  input  logic [21:0]           side_sq,
  input  logic                  mode,
  input  logic                  q_pop,
  output logic                  q_push,
  output tnl_pkg::qent_t        q_din
);
  import tnl_pkg::*;

  localparam int CRW = $clog2(QDEPTH + 1);

  logic [CRW-1:0] cred_r, cred_nxt;
  logic           acc;
  logic           v1_r, err1_r, mode1_r;
  logic [9:0]     x1_r, y1_r, z1_r;
  logic           err_in;
  logic           v2_r, err2_r, mode2_r;
  axis_t [2:0]    ax2_r, ax_nxt;
  logic [IW-1:0]  px2_r, py2_r, px_nxt, py_nxt;
  logic [9:0]     z2_r;

  function automatic axis_t build_axis(logic [9:0] c, logic [SW-1:0] s);
    slot_t lo;
    slot_t mid;
    slot_t hi;
    lo.val  = (c == '0) ? CW'(s - 1'b1) : CW'(c) - 1'b1;
    lo.ctr  = 1'b0;
    mid.val = CW'(c);
    mid.ctr = 1'b1;
    hi.val  = ({1'b0, c} + 1'b1 == s) ? '0 : CW'(c) + 1'b1;
    hi.ctr  = 1'b0;
    return sort3(lo, mid, hi);
  endfunction

  assign in_full = (cred_r == '0);
  assign acc     = in_push && !in_full;

  assign err_in = (side == '0) || (side > SW'(MAX_SIDE)) ||
                  ({1'b0, in_coord_x} >= side) || ({1'b0, in_coord_y} >= side) ||
                  ({1'b0, in_coord_z} >= side) || ((mode == MODE_BOX) && (side < 11'd3));

  always_comb begin
    cred_nxt = cred_r;
    if (acc && !q_pop) cred_nxt = cred_r - 1'b1;
    else if (q_pop && !acc) cred_nxt = cred_r + 1'b1;
  end

  always_comb begin
    ax_nxt[0] = build_axis(x1_r, side);
    ax_nxt[1] = build_axis(y1_r, side);
    ax_nxt[2] = build_axis(z1_r, side);
    px_nxt    = IW'({22'd0, x1_r} * {10'd0, side_sq});
    py_nxt    = IW'({11'd0, y1_r} * {10'd0, side});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= CRW'(QDEPTH);
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      cred_r <= cred_nxt;
      v1_r   <= acc;
      v2_r   <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x1_r    <= in_coord_x;
      y1_r    <= in_coord_y;
      z1_r    <= in_coord_z;
      err1_r  <= err_in;
      mode1_r <= mode;
    end
    if (v1_r) begin
      ax2_r   <= ax_nxt;
      px2_r   <= px_nxt;
      py2_r   <= py_nxt;
      z2_r    <= z1_r;
      err2_r  <= err1_r;
      mode2_r <= mode1_r;
    end
  end

  assign q_push     = v2_r;
  assign q_din.err  = err2_r;
  assign q_din.mode = mode2_r;
  assign q_din.vid  = err2_r ? '0 : px2_r + py2_r + IW'(z2_r);
  assign q_din.ax   = ax2_r;

  a_cred_max: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRW'(QDEPTH)) else $error("front credit overflow");
  a_no_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !acc) else $error("beat accepted while full");
  a_push_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> q_push) else $error("front stage dropped a beat");

endmodule

[design/tnl_back.sv]
// Back end: walks the 3x3x3 box of sorted axis values in row-major order
// and computes neighbour ids. Depends on tnl_pkg.
module tnl_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  tnl_pkg::qent_t         q_head,
  output logic                   q_pop,
  input  logic [tnl_pkg::SW-1:0] side,
  input  logic [21:0]            side_sq,
  input  logic                   o_pop,
  output logic                   o_push,
  output tnl_pkg::oent_t         o_din
);
  import tnl_pkg::*;

  localparam int OCW = $clog2(ODEPTH + 1);

  logic [OCW-1:0] ocred_r, ocred_nxt;
  logic [1:0]     i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;
  slot_t          sx, sy, sz;
  logic [1:0]     nc;
  logic           qual, issue, step, at_end;
  logic           v1_r, v2_r;
  logic [CW-1:0]  x1_r, y1_r, z1_r, z2_r;
  logic [IW-1:0]  vid1_r, vid2_r, px2_r, py2_r;
  logic [SLW-1:0] slot1_r, slot2_r;
  logic           last1_r, err1_r, last2_r, err2_r;

  assign sx = q_head.ax[0][i_r];
  assign sy = q_head.ax[1][j_r];
  assign sz = q_head.ax[2][k_r];
  assign nc = 2'(!sx.ctr) + 2'(!sy.ctr) + 2'(!sz.ctr);
  assign qual = q_head.err ||
                ((q_head.mode == MODE_BOX) ? (nc != 2'd0) : (nc == 2'd1));
  assign issue  = !q_empty && qual && (ocred_r != '0);
  assign step   = !q_empty && (!qual || (ocred_r != '0));
  assign at_end = q_head.err || (i_r == 2'd2 && j_r == 2'd2 && k_r == 2'd2);
  assign q_pop  = step && at_end;

  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    slot_nxt = slot_r;
    if (step) begin
      if (at_end) begin
        i_nxt    = '0;
        j_nxt    = '0;
        k_nxt    = '0;
        slot_nxt = '0;
      end else begin
        if (issue) slot_nxt = slot_r + 1'b1;
        if (k_r == 2'd2) begin
          k_nxt = '0;
          if (j_r == 2'd2) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ocred_nxt = ocred_r;
    if (issue && !o_pop) ocred_nxt = ocred_r - 1'b1;
    else if (o_pop && !issue) ocred_nxt = ocred_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocred_r <= OCW'(ODEPTH);
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      slot_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      ocred_r <= ocred_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      slot_r  <= slot_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      x1_r    <= q_head.err ? '0 : sx.val;
      y1_r    <= q_head.err ? '0 : sy.val;
      z1_r    <= q_head.err ? '0 : sz.val;
      vid1_r  <= q_head.vid;
      slot1_r <= q_head.err ? '0 : slot_r;
      err1_r  <= q_head.err;
      last1_r <= q_head.err ||
                 (slot_r == ((q_head.mode == MODE_BOX) ? SLW'(BOX_COUNT - 1)
                                                       : SLW'(FACE_COUNT - 1)));
    end
    if (v1_r) begin
      px2_r   <= IW'({22'd0, x1_r} * {11'd0, side_sq});
      py2_r   <= IW'({11'd0, y1_r} * {11'd0, side});
      z2_r    <= z1_r;
      vid2_r  <= vid1_r;
      slot2_r <= slot1_r;
      last2_r <= last1_r;
      err2_r  <= err1_r;
    end
  end

  assign o_push     = v2_r;
  assign o_din.vid  = vid2_r;
  assign o_din.slot = slot2_r;
  assign o_din.nid  = px2_r + py2_r + IW'(z2_r);
  assign o_din.last = last2_r;
  assign o_din.err  = err2_r;

  a_ocred_max: assert property (@(posedge clk) disable iff (!rst_n)
    ocred_r <= OCW'(ODEPTH)) else $error("output credit overflow");
  a_issue_cred: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ocred_r != '0) else $error("beat issued without credit");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLW'(BOX_COUNT + 1)) else $error("slot beyond box size");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (slot_r == '0 && k_r == '0)) else $error("walker not rewound");

endmodule

[design/torus_3d_neighbour_lister.sv]
// Lists the torus neighbours of a vertex as ascending row-major ids.
// Depends on tnl_pkg, tnl_fifo, tnl_front and tnl_back.
//
// Each accepted vertex yields a run of beats: six face neighbours in mode 0,
// 26 box neighbours in mode 1, or one error beat. The back end visits all
// 27 positions of the 3x3x3 box, one per cycle unless it must issue a beat
// and has no result-queue credit, so a valid vertex occupies it for all 27
// positions in either mode (26 or 6 beats), an error vertex for one. Input
// and output are decoupled by a 4-entry vertex queue and an 8-entry result queue.
module torus_3d_neighbour_lister #(
  parameter int MAX_SIDE = tnl_pkg::DEF_MAX_SIDE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [9:0]              in_coord_x,
  input  logic [9:0]              in_coord_y,
  input  logic [9:0]              in_coord_z,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [tnl_pkg::IW-1:0]  out_vertex_id,
  output logic [tnl_pkg::SLW-1:0] out_slot,
  output logic [tnl_pkg::IW-1:0]  out_neighbour_id,
  output logic                    out_last,
  output logic                    out_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [tnl_pkg::SW-1:0]  cfg_data
);
  import tnl_pkg::*;

  logic [SW-1:0] side_r;
  logic          mode_r;
  logic [21:0]   side_sq_r;
  logic          q_push, q_pop, q_empty, q_full;
  qent_t         q_din, q_head;
  logic          o_push, o_full;
  oent_t         o_din, o_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      mode_r <= MODE_FACE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIDE: side_r <= cfg_data;
        REG_MODE: mode_r <= cfg_data[0];
        default:  side_r <= side_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    side_sq_r <= 22'({11'd0, side_r} * {11'd0, side_r});
  end

  tnl_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_coord_x, .in_coord_y, .in_coord_z,
    .side(side_r), .side_sq(side_sq_r), .mode(mode_r),
    .q_pop, .q_push, .q_din
  );

  tnl_fifo #(.W($bits(qent_t)), .DEPTH(QDEPTH)) u_vq (
    .clk, .rst_n, .push(q_push), .din(q_din), .pop(q_pop),
    .dout(q_head), .empty(q_empty), .full(q_full)
  );

  tnl_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop,
    .side(side_r), .side_sq(side_sq_r),
    .o_pop(out_pop && !out_empty), .o_push, .o_din
  );

  tnl_fifo #(.W($bits(oent_t)), .DEPTH(ODEPTH)) u_oq (
    .clk, .rst_n, .push(o_push), .din(o_din), .pop(out_pop),
    .dout(o_head), .empty(out_empty), .full(o_full)
  );

  assign out_vertex_id    = o_head.vid;
  assign out_slot         = o_head.slot;
  assign out_neighbour_id = o_head.nid;
  assign out_last         = o_head.last;
  assign out_error        = o_head.err;

  a_vq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("vertex queue overflow");
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full) else $error("result queue overflow");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error) |-> out_last) else $error("error beat not last");

endmodule
